### hdl/mmpid_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the multi-mode PID controller.
// No dependencies; used by mmpid_smac and multi_mode_pid_controller.
package mmpid_pkg;

  // Field widths
  localparam int DATA_W     = 16;              // input sample fields
  localparam int ERR_W      = DATA_W + 1;      // exact error
  localparam int DIFF_W     = ERR_W + 1;       // error minus previous error
  localparam int INTEG_W    = 12;              // integral accumulator
  localparam int GAIN_W     = 16;              // signed Q8.8 gains
  localparam int WIN_W      = 15;              // window thresholds
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DRIVE_W    = 32;
  localparam int FRAC_W     = 8;               // Q8.8 fraction bits

  // Serial multiply-accumulate sizing
  localparam int MC_W     = 2 * ERR_W;         // widest multiplicand (dynamic P gain)
  localparam int MP_W     = DIFF_W;            // multiplier operand, radix-4 digits
  localparam int DIGITS   = MP_W / 2;
  localparam int CNT_W    = $clog2(DIGITS);
  localparam int ACC_W    = 56;
  localparam int Q_W      = ACC_W - FRAC_W;
  localparam int NUM_PASS = 3;
  localparam int PASS_W   = 2;

  // Constants of the control laws
  localparam int INTEG_LIMIT      = 2000;
  localparam int IWIN_RESET       = 6;
  localparam int DWIN_RESET       = 2;
  localparam int SAT16_MAX        = 32767;
  localparam int SAT16_MIN        = -32768;

  typedef enum logic [MODE_W-1:0] {
    MODE_POS  = 2'd0,   // positional PID
    MODE_INCR = 2'd1,   // incremental PI with feedforward
    MODE_DYNP = 2'd2,   // PD with error-dependent P gain
    MODE_RATE = 2'd3    // PD with rate term
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_GAIN_FF   = 3'd4,
    REG_GAIN_RATE = 3'd5,
    REG_IWIN      = 3'd6,
    REG_DWIN      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_RUN,
    ST_ROUND,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic                     start;
    logic                     acc_load;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [MC_W-1:0]   mcand;
    logic signed [MP_W-1:0]   mplier;
  } mac_cmd_t;

endpackage

### hdl/multi_mode_pid_controller.sv
`timescale 1ns / 1ps
// Multi-mode PID controller top level: sequencer, operand preparation, loop state.
// Depends on mmpid_pkg and mmpid_smac.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control sample per transaction:
//   setpoint, measured, direct_error and rate. Output channel (out_valid/out_ready)
//   returns one drive value per sample, in order.
//   Configuration: pulse cfg_we with cfg_index/cfg_wdata; write only while idle.
//   Each sample passes through the single serial MAC in turn: a preparation
//   step, then three products per sample, each an issue step followed by radix-4
//   Booth digit steps, then one round and one saturate step. No new sample is
//   taken until the current one has passed the saturate step.
//   A finished drive value waits in the output register; the block takes a new
//   sample meanwhile and only holds at the saturate step if that register is
//   still full when the next result is ready.
//   Reset (synchronous, rst_n low) clears gains, mode, windows (to 6 and 2),
//   integral, previous error and previous setpoint, and drops any result pending.
module multi_mode_pid_controller (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [mmpid_pkg::DATA_W-1:0]       in_setpoint,
  input  logic signed [mmpid_pkg::DATA_W-1:0]       in_measured,
  input  logic signed [mmpid_pkg::DATA_W-1:0]       in_direct_error,
  input  logic signed [mmpid_pkg::DATA_W-1:0]       in_rate,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [mmpid_pkg::DRIVE_W-1:0]      out_drive,
  input  logic                                      cfg_we,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mmpid_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mmpid_pkg::mode_t                      mode_r;
  logic signed [mmpid_pkg::GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r, gain_ff_r, gain_rate_r;
  logic [mmpid_pkg::WIN_W-1:0]           iwin_r, dwin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mmpid_pkg::MODE_POS;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      gain_ff_r   <= '0;
      gain_rate_r <= '0;
      iwin_r      <= mmpid_pkg::WIN_W'(mmpid_pkg::IWIN_RESET);
      dwin_r      <= mmpid_pkg::WIN_W'(mmpid_pkg::DWIN_RESET);
    end else if (cfg_we) begin
      case (mmpid_pkg::reg_idx_t'(cfg_index))
        mmpid_pkg::REG_MODE: begin
          mode_r <= mmpid_pkg::mode_t'(cfg_wdata[mmpid_pkg::MODE_W-1:0]);
        end
        mmpid_pkg::REG_GAIN_P:    gain_p_r    <= $signed(cfg_wdata[mmpid_pkg::GAIN_W-1:0]);
        mmpid_pkg::REG_GAIN_I:    gain_i_r    <= $signed(cfg_wdata[mmpid_pkg::GAIN_W-1:0]);
        mmpid_pkg::REG_GAIN_D:    gain_d_r    <= $signed(cfg_wdata[mmpid_pkg::GAIN_W-1:0]);
        mmpid_pkg::REG_GAIN_FF:   gain_ff_r   <= $signed(cfg_wdata[mmpid_pkg::GAIN_W-1:0]);
        mmpid_pkg::REG_GAIN_RATE: gain_rate_r <= $signed(cfg_wdata[mmpid_pkg::GAIN_W-1:0]);
        mmpid_pkg::REG_IWIN:      iwin_r      <= cfg_wdata[mmpid_pkg::WIN_W-1:0];
        mmpid_pkg::REG_DWIN:      dwin_r      <= cfg_wdata[mmpid_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  mmpid_pkg::state_t             state_r, state_nxt;
  logic [mmpid_pkg::PASS_W-1:0]  pass_r, pass_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          mac_done;
  logic                          take_in, prep_en, round_en, sat_ld, last_pass;
  mmpid_pkg::mac_cmd_t           mac_cmd;
  logic signed [mmpid_pkg::ACC_W-1:0] acc;

  assign last_pass = (pass_r == mmpid_pkg::PASS_W'(mmpid_pkg::NUM_PASS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmpid_pkg::ST_IDLE:  if (in_valid) state_nxt = mmpid_pkg::ST_PREP;
      mmpid_pkg::ST_PREP:  state_nxt = mmpid_pkg::ST_ISSUE;
      mmpid_pkg::ST_ISSUE: state_nxt = mmpid_pkg::ST_RUN;
      mmpid_pkg::ST_RUN: begin
        if (mac_done) begin
          state_nxt = last_pass ? mmpid_pkg::ST_ROUND : mmpid_pkg::ST_ISSUE;
        end
      end
      mmpid_pkg::ST_ROUND: state_nxt = mmpid_pkg::ST_SAT;
      mmpid_pkg::ST_SAT:   if (!out_valid_r || out_ready) state_nxt = mmpid_pkg::ST_IDLE;
      default:             state_nxt = mmpid_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    prep_en  = 1'b0;
    round_en = 1'b0;
    sat_ld   = 1'b0;
    case (state_r)
      mmpid_pkg::ST_IDLE:  in_ready = 1'b1;
      mmpid_pkg::ST_PREP:  prep_en  = 1'b1;
      mmpid_pkg::ST_ROUND: round_en = 1'b1;
      mmpid_pkg::ST_SAT:   sat_ld   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign take_in = in_valid && in_ready;

  // Count passes; advance on each MAC completion but the last
  always_comb begin
    pass_nxt = pass_r;
    if (prep_en) begin
      pass_nxt = '0;
    end else if (state_r == mmpid_pkg::ST_RUN && mac_done && !last_pass) begin
      pass_nxt = pass_r + 1'b1;
    end
  end

  // Output register: load on saturate step, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (sat_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmpid_pkg::ST_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample capture and operand preparation
  // ---------------------------------------------------------------------------
  logic signed [mmpid_pkg::DATA_W-1:0]  sp_r, meas_r, derr_r, rate_r;
  logic signed [mmpid_pkg::ERR_W-1:0]   err_r, dsp_r;
  logic signed [mmpid_pkg::DIFF_W-1:0]  de_r;
  logic signed [mmpid_pkg::INTEG_W-1:0] isn_r;
  logic                                 win_r;

  // Loop state
  logic signed [mmpid_pkg::INTEG_W-1:0] integ_r;
  logic signed [mmpid_pkg::ERR_W-1:0]   perr_r;
  logic signed [mmpid_pkg::DATA_W-1:0]  psp_r;

  logic signed [mmpid_pkg::ERR_W-1:0]   e_c, err_c, dsp_c;
  logic signed [mmpid_pkg::DIFF_W-1:0]  de_c;
  logic signed [mmpid_pkg::ERR_W:0]     isum_c;
  logic signed [mmpid_pkg::INTEG_W-1:0] isn_c;
  logic [mmpid_pkg::ERR_W-1:0]          mag_c, thr_c;
  logic                                 win_c;

  always_ff @(posedge clk) begin
    if (take_in) begin
      sp_r   <= in_setpoint;
      meas_r <= in_measured;
      derr_r <= in_direct_error;
      rate_r <= in_rate;
    end
  end

  always_comb begin
    e_c   = mmpid_pkg::ERR_W'(sp_r) - mmpid_pkg::ERR_W'(meas_r);
    // Mode 3 runs on the error handed in directly
    err_c = (mode_r == mmpid_pkg::MODE_RATE) ? mmpid_pkg::ERR_W'(derr_r) : e_c;
    de_c  = mmpid_pkg::DIFF_W'(err_c) - mmpid_pkg::DIFF_W'(perr_r);
    dsp_c = mmpid_pkg::ERR_W'(sp_r) - mmpid_pkg::ERR_W'(psp_r);

    // Integral with clamp to plus or minus the limit
    isum_c = (mmpid_pkg::ERR_W + 1)'(integ_r) + (mmpid_pkg::ERR_W + 1)'(e_c);
    if (isum_c > (mmpid_pkg::ERR_W + 1)'(mmpid_pkg::INTEG_LIMIT)) begin
      isn_c = mmpid_pkg::INTEG_W'(mmpid_pkg::INTEG_LIMIT);
    end else if (isum_c < (mmpid_pkg::ERR_W + 1)'(-mmpid_pkg::INTEG_LIMIT)) begin
      isn_c = mmpid_pkg::INTEG_W'(-mmpid_pkg::INTEG_LIMIT);
    end else begin
      isn_c = isum_c[mmpid_pkg::INTEG_W-1:0];
    end

    // Window gate: magnitude of the error against the mode's threshold
    mag_c = err_c[mmpid_pkg::ERR_W-1] ? mmpid_pkg::ERR_W'(-err_c) : mmpid_pkg::ERR_W'(err_c);
    thr_c = (mode_r == mmpid_pkg::MODE_INCR) ? mmpid_pkg::ERR_W'(iwin_r)
                                             : mmpid_pkg::ERR_W'(dwin_r);
    win_c = mag_c < thr_c;
  end

  always_ff @(posedge clk) begin
    if (prep_en) begin
      err_r <= err_c;
      de_r  <= de_c;
      dsp_r <= dsp_c;
      isn_r <= isn_c;
      win_r <= win_c;
    end
  end

  // Loop state advances once per sample, in the preparation cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
      psp_r   <= '0;
    end else if (prep_en) begin
      perr_r <= err_c;
      if (mode_r == mmpid_pkg::MODE_POS) begin
        integ_r <= isn_c;
      end
      if (mode_r == mmpid_pkg::MODE_INCR) begin
        psp_r <= sp_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pass operands: three products per sample into one accumulator.
  // The dynamic-P law builds its gain in the first pass, then feeds the
  // accumulator back as the multiplicand of the second.
  // ---------------------------------------------------------------------------
  always_comb begin
    mac_cmd.start    = (state_r == mmpid_pkg::ST_ISSUE);
    mac_cmd.acc_load = 1'b0;
    mac_cmd.acc_init = '0;
    mac_cmd.mcand    = '0;
    mac_cmd.mplier   = '0;
    case (mode_r)
      mmpid_pkg::MODE_POS: begin
        case (pass_r)
          2'd0: begin
            mac_cmd.acc_load = 1'b1;
            mac_cmd.mcand    = mmpid_pkg::MC_W'(gain_p_r);
            mac_cmd.mplier   = mmpid_pkg::MP_W'(err_r);
          end
          2'd1: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_i_r);
            mac_cmd.mplier = mmpid_pkg::MP_W'(isn_r);
          end
          default: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_d_r);
            mac_cmd.mplier = de_r;
          end
        endcase
      end
      mmpid_pkg::MODE_INCR: begin
        case (pass_r)
          2'd0: begin
            mac_cmd.acc_load = 1'b1;
            mac_cmd.mcand    = mmpid_pkg::MC_W'(gain_p_r);
            mac_cmd.mplier   = de_r;
          end
          2'd1: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_ff_r);
            mac_cmd.mplier = mmpid_pkg::MP_W'(dsp_r);
          end
          default: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_i_r);
            mac_cmd.mplier = win_r ? mmpid_pkg::MP_W'(err_r) : '0;
          end
        endcase
      end
      mmpid_pkg::MODE_DYNP: begin
        case (pass_r)
          2'd0: begin
            // Gain slope times error, seeded with the base gain
            mac_cmd.acc_load = 1'b1;
            mac_cmd.acc_init = mmpid_pkg::ACC_W'(gain_p_r);
            mac_cmd.mcand    = mmpid_pkg::MC_W'(gain_i_r);
            mac_cmd.mplier   = mmpid_pkg::MP_W'(err_r);
          end
          2'd1: begin
            mac_cmd.acc_load = 1'b1;
            mac_cmd.mcand    = $signed(acc[mmpid_pkg::MC_W-1:0]);
            mac_cmd.mplier   = mmpid_pkg::MP_W'(err_r);
          end
          default: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_d_r);
            mac_cmd.mplier = de_r;
          end
        endcase
      end
      default: begin
        case (pass_r)
          2'd0: begin
            mac_cmd.acc_load = 1'b1;
            mac_cmd.mcand    = mmpid_pkg::MC_W'(gain_p_r);
            mac_cmd.mplier   = mmpid_pkg::MP_W'(err_r);
          end
          2'd1: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_rate_r);
            mac_cmd.mplier = mmpid_pkg::MP_W'(rate_r);
          end
          default: begin
            mac_cmd.mcand  = mmpid_pkg::MC_W'(gain_d_r);
            mac_cmd.mplier = win_r ? de_r : '0;
          end
        endcase
      end
    endcase
  end

  mmpid_smac u_smac (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mac_cmd),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // Truncate toward zero, then saturate
  // ---------------------------------------------------------------------------
  logic signed [mmpid_pkg::ACC_W-1:0]   biased_c;
  logic signed [mmpid_pkg::Q_W-1:0]     q_r;
  logic signed [mmpid_pkg::Q_W-1:0]     lim_hi_c, lim_lo_c, sat_c;
  logic signed [mmpid_pkg::DRIVE_W-1:0] drive_r;

  // Negative sums get 255/256 added so the shift rounds toward zero
  assign biased_c = acc + (acc[mmpid_pkg::ACC_W-1]
                    ? mmpid_pkg::ACC_W'((1 << mmpid_pkg::FRAC_W) - 1)
                    : mmpid_pkg::ACC_W'(0));

  always_ff @(posedge clk) begin
    if (round_en) begin
      q_r <= biased_c[mmpid_pkg::ACC_W-1:mmpid_pkg::FRAC_W];
    end
  end

  always_comb begin
    if (mode_r == mmpid_pkg::MODE_POS || mode_r == mmpid_pkg::MODE_DYNP) begin
      lim_hi_c = mmpid_pkg::Q_W'(mmpid_pkg::SAT16_MAX);
      lim_lo_c = mmpid_pkg::Q_W'(mmpid_pkg::SAT16_MIN);
    end else begin
      lim_hi_c = mmpid_pkg::Q_W'(64'sh7FFF_FFFF);
      lim_lo_c = mmpid_pkg::Q_W'(-64'sh8000_0000);
    end
    if (q_r > lim_hi_c) begin
      sat_c = lim_hi_c;
    end else if (q_r < lim_lo_c) begin
      sat_c = lim_lo_c;
    end else begin
      sat_c = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sat_ld) begin
      drive_r <= sat_c[mmpid_pkg::DRIVE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

endmodule

### hdl/mmpid_smac.sv
`timescale 1ns / 1ps
// Digit-serial signed multiply-accumulate: radix-4 Booth, two multiplier bits per cycle.
// Depends on mmpid_pkg.
module mmpid_smac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mmpid_pkg::mac_cmd_t                    cmd,
  output logic                                   done_o,
  output logic signed [mmpid_pkg::ACC_W-1:0]     acc_o
);

  logic signed [mmpid_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [mmpid_pkg::ACC_W-1:0] mc_r, mc_nxt;
  logic signed [mmpid_pkg::MP_W:0]    mp_r, mp_nxt;
  logic [mmpid_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                               busy_r, busy_nxt;

  logic                               dig_neg, dig_one, dig_two, last;
  logic signed [mmpid_pkg::ACC_W-1:0] pp_mag, pp;

  // Booth recode of the low three bits
  always_comb begin
    dig_neg = mp_r[2];
    dig_one = mp_r[1] ^ mp_r[0];
    dig_two = (mp_r[2] & ~mp_r[1] & ~mp_r[0]) | (~mp_r[2] & mp_r[1] & mp_r[0]);
    if (dig_two) begin
      pp_mag = mc_r <<< 1;
    end else if (dig_one) begin
      pp_mag = mc_r;
    end else begin
      pp_mag = '0;
    end
    pp = dig_neg ? -pp_mag : pp_mag;
  end

  assign last = busy_r && (cnt_r == mmpid_pkg::CNT_W'(mmpid_pkg::DIGITS - 1));

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      acc_nxt  = cmd.acc_load ? cmd.acc_init : acc_r;
      mc_nxt   = mmpid_pkg::ACC_W'(cmd.mcand);
      mp_nxt   = {cmd.mplier, 1'b0};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = acc_r + pp;
      mc_nxt   = mc_r <<< 2;
      mp_nxt   = mp_r >>> 2;
      cnt_nxt  = cnt_r + 1'b1;
      busy_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done_o = last;
  assign acc_o  = acc_r;

endmodule
